@@ rtl/itlc_pkg.sv @@
// shared types and constants of the inode table with link counts
package itlc_pkg;

  localparam int unsigned TableEntriesDef = 128;
  localparam int unsigned LinkBitsDef     = 16;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned TypeW = 4;
  localparam int unsigned ModeW = 32;
  localparam int unsigned SizeW = 64;
  localparam int unsigned CntW  = 16;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_SETSZ  = 3'd2,
    ACT_LINK   = 3'd3,
    ACT_COUNT  = 3'd4,
    ACT_UNLINK = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_FILE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [KeyW-1:0]  inode_key;
    logic [TypeW-1:0] new_type;
    logic [ModeW-1:0] new_mode;
    logic [SizeW-1:0] new_size;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [KeyW-1:0]  inode_out;
    logic [TypeW-1:0] type_out;
    logic [ModeW-1:0] mode_out;
    logic [SizeW-1:0] size_out;
    logic [CntW-1:0]  link_count;
  } out_t;

  typedef struct packed {
    logic [TypeW-1:0] file_type_code;
    logic [TypeW-1:0] last_type_code;
  } cfg_t;

endpackage

@@ rtl/itlc_mem.sv @@
// single-port-write, single-port-read table memory with registered read data
module itlc_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 181
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/itlc_ctrl.sv @@
// table sequencer: clearing pass, entry scan, read-modify-write and result register
module itlc_ctrl #(
  parameter int unsigned TABLE_ENTRIES = itlc_pkg::TableEntriesDef,
  parameter int unsigned LINK_BITS     = itlc_pkg::LinkBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itlc_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itlc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output itlc_pkg::out_t out_data_o
);
  import itlc_pkg::*;

  localparam int unsigned AW       = $clog2(TABLE_ENTRIES);
  localparam int unsigned LW       = LINK_BITS;
  localparam int unsigned SizeLo   = LW;
  localparam int unsigned ModeLo   = LW + SizeW;
  localparam int unsigned TypeLo   = ModeLo + ModeW;
  localparam int unsigned InoLo    = TypeLo + TypeW;
  localparam int unsigned ValidBit = InoLo + KeyW;
  localparam int unsigned WW       = ValidBit + 1;

  ctrl_state_e     state_q, state_d;
  logic [AW-1:0]   iss_q, iss_d;
  logic            iss_done_q, iss_done_d;
  logic            rd_pend_q, rd_pend_d;
  logic [AW-1:0]   rd_idx_q, rd_idx_d;
  in_t             req_q, req_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [KeyW-1:0] next_ino_q, next_ino_d;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [WW-1:0]   mem_wdata, rdata;

  logic             r_valid;
  logic [KeyW-1:0]  r_ino;
  logic [TypeW-1:0] r_type;
  logic [ModeW-1:0] r_mode;
  logic [SizeW-1:0] r_size;
  logic [LW-1:0]    r_links;
  logic             hit, issuing, bad_type;

  assign r_valid = rdata[ValidBit];
  assign r_ino   = rdata[InoLo +: KeyW];
  assign r_type  = rdata[TypeLo +: TypeW];
  assign r_mode  = rdata[ModeLo +: ModeW];
  assign r_size  = rdata[SizeLo +: SizeW];
  assign r_links = rdata[LW-1:0];

  // create looks for the first free slot, everything else for the first matching entry
  assign hit = (req_q.action == ACT_CREATE) ? !r_valid
                                            : (r_valid && (r_ino == req_q.inode_key));
  assign issuing  = (state_q == S_SCAN) && !iss_done_q;
  assign bad_type = (in_data_i.new_type < cfg_i.file_type_code) ||
                    (in_data_i.new_type > cfg_i.last_type_code);

  itlc_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (WW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (iss_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    iss_done_d  = iss_done_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    next_ino_d  = next_ino_q;
    mem_we      = 1'b0;
    mem_re      = issuing;
    mem_waddr   = rd_idx_q;
    mem_wdata   = rdata;
    in_ready_o  = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = iss_q;
        mem_wdata = '0;
        iss_d     = iss_q + 1'b1;
        if (iss_q == AW'(TABLE_ENTRIES - 1)) begin
          iss_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_data_i;
          iss_d      = '0;
          iss_done_d = 1'b0;
          res_d      = '0;
          case (in_data_i.action)
            ACT_CREATE: begin
              if (bad_type) begin
                res_d.status = ST_BAD_TYPE;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_LOOKUP, ACT_SETSZ, ACT_LINK, ACT_COUNT, ACT_UNLINK: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one read issued per cycle, the previous read checked against the request
        if (issuing) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = iss_q;
          iss_d     = iss_q + 1'b1;
          if (iss_q == AW'(TABLE_ENTRIES - 1)) begin
            iss_done_d = 1'b1;
          end
        end
        if (rd_pend_q && hit) begin
          res_d     = '0;
          state_d   = S_DONE;
          mem_wdata = rdata;
          case (req_q.action)
            ACT_CREATE: begin
              mem_we                          = 1'b1;
              mem_wdata                       = '0;
              mem_wdata[ValidBit]             = 1'b1;
              mem_wdata[InoLo +: KeyW]        = next_ino_q;
              mem_wdata[TypeLo +: TypeW]      = req_q.new_type;
              mem_wdata[ModeLo +: ModeW]      = req_q.new_mode;
              mem_wdata[LW-1:0]               = LW'(1);
              res_d.inode_out                 = next_ino_q;
              next_ino_d                      = next_ino_q + 1'b1;
            end
            ACT_LOOKUP: begin
              res_d.type_out = r_type;
              res_d.mode_out = r_mode;
              res_d.size_out = r_size;
            end
            ACT_SETSZ: begin
              if (r_type != cfg_i.file_type_code) begin
                res_d.status = ST_NOT_FILE;
              end else begin
                mem_we                     = 1'b1;
                mem_wdata[SizeLo +: SizeW] = req_q.new_size;
              end
            end
            ACT_LINK: begin
              // saturates at the all-ones count
              if (r_links != {LW{1'b1}}) begin
                mem_we             = 1'b1;
                mem_wdata[LW-1:0]  = r_links + 1'b1;
                res_d.link_count   = CntW'(r_links + 1'b1);
              end else begin
                res_d.link_count   = CntW'(r_links);
              end
            end
            ACT_COUNT: begin
              res_d.link_count = CntW'(r_links);
            end
            ACT_UNLINK: begin
              mem_we = 1'b1;
              if (r_links <= LW'(1)) begin
                mem_wdata[LW-1:0]   = '0;
                mem_wdata[ValidBit] = 1'b0;
                res_d.link_count    = '0;
              end else begin
                mem_wdata[LW-1:0]   = r_links - 1'b1;
                res_d.link_count    = CntW'(r_links - 1'b1);
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end else if (iss_done_q && !rd_pend_q) begin
          res_d   = '0;
          state_d = S_DONE;
          if (req_q.action == ACT_CREATE) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      iss_q       <= '0;
      iss_done_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      next_ino_q  <= KeyW'(1);
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      iss_done_q  <= iss_done_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      next_ino_q  <= next_ino_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    req_q    <= req_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/inode_table_link_count.sv @@
// top level of the inode table: configuration registers and table sequencer
//
// Requests arrive on the in channel (valid/ready) as one transaction each and
// every request gives exactly one result transaction on the out channel.
// Create takes the lowest free slot and hands out the next inode number;
// lookup, set size, link, count and unlink find the lowest valid entry with
// the given inode number. Two type-range registers sit on the APB port at
// byte addresses 0 and 4; they are to be written only while the block is
// idle, and the block itself does not enforce this. After reset the table
// memory is swept clear entry by entry, and no request is taken during the
// sweep. A request then scans the table memory through its single read
// port, one entry per cycle, and stops at the first hit; a miss or a full
// table is reported once the last slot has been read. Bad-type and unknown
// requests skip the scan. The next request is taken once the result has
// moved into the output register and the block is back in idle, so one
// request is in flight at a time. A stalled receiver does not block the
// next request; only the following result waits until the held one is taken.
module inode_table_link_count #(
  parameter int unsigned TABLE_ENTRIES = itlc_pkg::TableEntriesDef,
  parameter int unsigned LINK_BITS     = itlc_pkg::LinkBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itlc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output itlc_pkg::out_t out_data_o
);
  import itlc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      if (paddr[2]) begin
        cfg_d.last_type_code = pwdata[TypeW-1:0];
      end else begin
        cfg_d.file_type_code = pwdata[TypeW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.file_type_code <= TypeW'(0);
      cfg_q.last_type_code <= TypeW'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = paddr[2] ? {{(32 - TypeW){1'b0}}, cfg_q.last_type_code}
                           : {{(32 - TypeW){1'b0}}, cfg_q.file_type_code};

  itlc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LINK_BITS     (LINK_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
